/* src/crlf_line_buffer_assert.svh */
// Assertion macros for the line buffer checker.
`ifndef CRLF_LINE_BUFFER_ASSERT_SVH
`define CRLF_LINE_BUFFER_ASSERT_SVH

// Checked on every rising edge outside reset.
`define CLB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define CLB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/clb_pkg.sv */
// ----------------------------------------------------------------------------
// clb_pkg
// Types, codes and sizes shared by the CR LF line buffer.
// ----------------------------------------------------------------------------
package clb_pkg;

  // Store geometry and counter widths
  localparam int BUF_DEPTH = 64;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int CAP_W     = 7;
  localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam logic [CAP_W-1:0] CAP_MIN   = 7'd2;
  localparam logic [5:0]       LEN_MAX   = 6'd63;

  // Operation codes
  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  // Push status codes
  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_COMPLETE = 2'd2;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] byte_in;
    logic [5:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       line_ready;
    logic [5:0] line_length;
    logic [7:0] read_data;
    logic       read_valid;
  } out_item_t;

  // Store access for one accepted item
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_cmd_t;

  // Result fields known at accept time; rd_sel picks the store byte
  typedef struct packed {
    logic [1:0] status;
    logic       line_ready;
    logic [5:0] line_length;
    logic       read_valid;
    logic       rd_sel;
  } meta_t;

endpackage

/* src/clb_store.sv */
// ----------------------------------------------------------------------------
// clb_store
// Line store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module clb_store
  import clb_pkg::*;
(
  input  logic     clk,
  input  mem_cmd_t cmd,
  output logic [7:0] rd_data
);

  logic [7:0] mem [BUF_DEPTH];

  // Write and registered read; read data holds while re is low
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    if (cmd.re) begin
      rd_data <= mem[cmd.raddr];
    end
  end

endmodule

/* src/clb_ctrl.sv */
// ----------------------------------------------------------------------------
// clb_ctrl
// Line state: fill count, CR tracking, discard mode and held flag.
// Issues the store access and the result fields for each accepted item.
// ----------------------------------------------------------------------------
module clb_ctrl
  import clb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  in_item_t         item,
  input  logic [CAP_W-1:0] capacity,
  output mem_cmd_t         cmd,
  output meta_t            meta
);

  logic [CNT_W-1:0] fill_length, fill_length_next;
  logic discarding, discarding_next;
  logic prev_cr_in_discard, prev_cr_in_discard_next;
  logic last_was_cr, last_was_cr_next;
  logic line_held, line_held_next;

  logic [CMP_W-1:0] cap_ext, eff_cap, fill_ext, idx_ext;
  logic             is_cr, is_lf, ended, overflow;
  logic [1:0]       status;

  assign is_cr    = (item.byte_in == CH_CR);
  assign is_lf    = (item.byte_in == CH_LF);
  assign fill_ext = CMP_W'(fill_length);
  assign idx_ext  = CMP_W'(item.read_index);

  // Capacity clamped into [2, depth]
  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (cap_ext < CMP_W'(CAP_MIN)) begin
      eff_cap = CMP_W'(CAP_MIN);
    end else if (cap_ext > CMP_W'(BUF_DEPTH)) begin
      eff_cap = CMP_W'(BUF_DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign overflow = ((fill_ext + CMP_W'(1)) >= eff_cap);

  // Next state, store access and result fields seen after the operation
  always_comb begin
    fill_length_next        = fill_length;
    discarding_next         = discarding;
    prev_cr_in_discard_next = prev_cr_in_discard;
    last_was_cr_next        = last_was_cr;
    line_held_next          = line_held;
    status                  = ST_NONE;
    ended                   = 1'b0;
    cmd.we                  = 1'b0;
    cmd.waddr               = ADDR_W'(fill_length);
    cmd.wdata               = item.byte_in;
    cmd.re                  = 1'b0;
    cmd.raddr               = ADDR_W'(item.read_index);
    meta.read_valid         = 1'b0;
    meta.rd_sel             = 1'b0;

    if (accept) begin
      case (item.operation)
        OP_PUSH: begin
          if (line_held) begin
            // held line: push ignored
          end else if (discarding) begin
            ended                   = prev_cr_in_discard && is_lf;
            prev_cr_in_discard_next = is_cr && !ended;
            discarding_next         = !ended;
          end else if (overflow) begin
            // drop partial line; a closing LF ends it right here
            ended                   = is_lf && (fill_length != '0) && last_was_cr;
            fill_length_next        = '0;
            last_was_cr_next        = 1'b0;
            discarding_next         = !ended;
            prev_cr_in_discard_next = !ended && is_cr;
            status                  = ST_TOO_LONG;
          end else begin
            ended            = (fill_length != '0) && last_was_cr && is_lf;
            cmd.we           = 1'b1;
            fill_length_next = fill_length + CNT_W'(1);
            last_was_cr_next = is_cr;
            if (ended) begin
              line_held_next = 1'b1;
              status         = ST_COMPLETE;
            end
          end
        end
        OP_READ: begin
          cmd.re          = 1'b1;
          meta.read_valid = line_held;
          meta.rd_sel     = line_held && (idx_ext < fill_ext) &&
                            (idx_ext < CMP_W'(BUF_DEPTH));
        end
        OP_RELEASE: begin
          fill_length_next        = '0;
          discarding_next         = 1'b0;
          prev_cr_in_discard_next = 1'b0;
          last_was_cr_next        = 1'b0;
          line_held_next          = 1'b0;
        end
        OP_NOP: begin
        end
        default: begin
        end
      endcase
    end

    meta.status      = status;
    meta.line_ready  = line_held_next;
    meta.line_length = '0;
    if (line_held_next) begin
      meta.line_length = (CMP_W'(fill_length_next) > CMP_W'(LEN_MAX)) ?
                         LEN_MAX : 6'(fill_length_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_length        <= '0;
      discarding         <= 1'b0;
      prev_cr_in_discard <= 1'b0;
      last_was_cr        <= 1'b0;
      line_held          <= 1'b0;
    end else begin
      fill_length        <= fill_length_next;
      discarding         <= discarding_next;
      prev_cr_in_discard <= prev_cr_in_discard_next;
      last_was_cr        <= last_was_cr_next;
      line_held          <= line_held_next;
    end
  end

endmodule

/* src/crlf_line_buffer.sv */
// ----------------------------------------------------------------------------
// crlf_line_buffer
// Collects bytes into a line store until CR LF, holds the line for reads
// until released.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_data  (in_item_t)
//  out     | output    | out_valid / out_ready | out_data (out_item_t)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_data (capacity)
//
// One item per cycle unless the output stalls; each item's result passes
// through the store read stage, then the output register.
// The single port pair sets the rate: at most one write or one read per item.
// Reset clears the line state and sets capacity to 64; the store holds no
// reset value and needs no clearing pass.
// With the output stalled, one more item is taken into the read stage before
// in_ready drops. cfg_ready is always high.
// ----------------------------------------------------------------------------
module crlf_line_buffer
  import clb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  logic [CAP_W-1:0] capacity;
  logic             accept, s1_valid, s1_adv;
  meta_t            meta, s1_meta;
  mem_cmd_t         cmd;
  logic [7:0]       rd_data;

  assign cfg_ready = 1'b1;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  // Handshake: read stage frees when it moves to the output register
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  clb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (in_data),
    .capacity (capacity),
    .cmd      (cmd),
    .meta     (meta)
  );

  clb_store u_store (
    .clk     (clk),
    .cmd     (cmd),
    .rd_data (rd_data)
  );

  // Read stage, aligned with the store's read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta <= meta;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data.status      <= s1_meta.status;
      out_data.line_ready  <= s1_meta.line_ready;
      out_data.line_length <= s1_meta.line_length;
      out_data.read_valid  <= s1_meta.read_valid;
      out_data.read_data   <= s1_meta.rd_sel ? rd_data : 8'd0;
    end
  end

endmodule

/* src/clb_checker.sv */
// ----------------------------------------------------------------------------
// clb_checker
// Port-level checks on the line buffer's result stream.
// ----------------------------------------------------------------------------
`include "crlf_line_buffer_assert.svh"

module clb_checker
  import clb_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input in_item_t         in_data,
  input logic             out_valid,
  input logic             out_ready,
  input out_item_t        out_data,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [CAP_W-1:0] cfg_data
);

  // A stalled result stays offered
  `CLB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // Reads give no push status
  `CLB_ASSERT(a_read_no_status, out_valid && out_data.read_valid |-> out_data.status == ST_NONE, "read with push status")

  // No held line: length and data read zero
  `CLB_ASSERT(a_idle_zero, out_valid && !out_data.line_ready |-> out_data.line_length == 6'd0 && out_data.read_data == 8'd0 && !out_data.read_valid, "fields set without held line")

  // Completion holds the line; overflow never does
  `CLB_ASSERT(a_complete_held, out_valid && out_data.status == ST_COMPLETE |-> out_data.line_ready && out_data.line_length >= 6'd2, "line complete but not held")
  `CLB_ASSERT_ALWAYS(a_long_not_held, rst || !(out_valid && out_data.status == ST_TOO_LONG && out_data.line_ready), "overflow with held line")

endmodule

bind crlf_line_buffer clb_checker u_clb_checker (.*);
